// ===== hdl/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

   // conversion selector
   typedef enum logic [1:0] {
      OP_SDEC = 2'd0,
      OP_UDEC = 2'd1,
      OP_LHEX = 2'd2,
      OP_UHEX = 2'd3
   } op_type;

   localparam int unsigned DIGIT_SLOTS = 10;
   localparam int unsigned DIGIT_IDX_W = 4;

   // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit_sign;
      logic emit_pad;
      logic emit_digit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic negative;
      logic mag_done;
      logic pad_left;
      logic last_digit;
      logic out_free;
   } status_type;

   function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UP_A : CHAR_LOW_A;
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'd0, d};
      end
      return base + {4'd0, d} - 8'd10;
   endfunction

endpackage

// ===== hdl/integer_to_ascii_formatter_top.sv =====
`timescale 1ns / 1ps

// integer to ascii formatter: takes one 32-bit argument per request beat with
// its conversion (signed decimal, unsigned decimal, lower or upper hex), a
// minimum field width (saturated at MAX_WIDTH) and a zero-pad flag, and sends
// the formatted characters one per response beat, most significant first, with
// rsp_tlast on the final digit. a negative signed value gives '-' first and its
// magnitude is padded to width-1; pad characters sit between sign and digits.
// one argument is worked on at a time: digits are pulled out one by one, each
// in a multiply state and a divide state (a registered 32x32 reciprocal multiply
// for decimal, a shift for hex), then characters go out through the output
// register, waiting whenever the sink is not ready.

module integer_to_ascii_formatter_top #(
   parameter int unsigned MAX_WIDTH = 63
) (
   input  logic        clock,
   input  logic        reset,
   // request: one argument per beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // op[1:0], value[33:2], field_width[39:34],
                                    // zero_pad[40], zeros[47:41]
   // response: one character per beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // ascii_char[7:0]
   output logic        rsp_tlast
);

   itoa_pkg::cmd_type    cmd;
   itoa_pkg::status_type status;

   // sequencer: accept, digit extraction loop, sign, pad run, digit run
   itoa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // argument registers, digit slots, pad counter and the output register
   itoa_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .in_op          (req_tdata[1:0]),
      .in_value       (req_tdata[33:2]),
      .in_field_width (req_tdata[39:34]),
      .in_zero_pad    (req_tdata[40]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_ascii_char (rsp_tdata),
      .rsp_last       (rsp_tlast)
   );

endmodule

// ===== hdl/itoa_ctrl.sv =====
`timescale 1ns / 1ps

module itoa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  itoa_pkg::status_type   status,
   output itoa_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_DIGIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.mag_done) begin
               state_in = status.negative ? ST_SIGN : ST_PAD;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_PAD;
            end
         end
         ST_PAD: begin
            if (!status.pad_left) begin
               state_in = ST_DIGIT;
            end else if (status.out_free) begin
               cmd.emit_pad = 1'b1;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/itoa_datapath.sv =====
`timescale 1ns / 1ps

module itoa_datapath #(
   parameter int unsigned MAX_WIDTH = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             in_op,
   input  logic [31:0]            in_value,
   input  logic [5:0]             in_field_width,
   input  logic                   in_zero_pad,
   input  itoa_pkg::cmd_type      cmd,
   output itoa_pkg::status_type   status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_ascii_char,
   output logic                   rsp_last
);

   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam logic [5:0]  MAX_W6 = 6'(MAX_WIDTH);
   localparam int unsigned IW = itoa_pkg::DIGIT_IDX_W;

   logic          hex_ff, upper_ff, zero_pad_ff, neg_ff;
   logic [31:0]   mag_ff, mag_in;
   logic [63:0]   prod_ff;
   logic [WW-1:0] width_ff, width_in;
   logic [IW-1:0] ndig_ff, ndig_in;
   logic [3:0]    slot_ff [itoa_pkg::DIGIT_SLOTS];
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff;
   logic          out_last_ff;

   logic          neg_new;
   logic [5:0]    sat_w;
   logic [31:0]   quot;
   logic [31:0]   rem_full;
   logic [3:0]    rem;
   logic          emit_any;
   logic [IW-1:0] rd_idx;

   assign neg_new = (itoa_pkg::op_type'(in_op) == itoa_pkg::OP_SDEC) && in_value[31];
   assign sat_w   = (in_field_width > MAX_W6) ? MAX_W6 : in_field_width;

   // one digit per step: shift for hex, reciprocal multiply for decimal
   always_comb begin
      if (hex_ff) begin
         quot     = {4'd0, mag_ff[31:4]};
         rem_full = {28'd0, mag_ff[3:0]};
      end else begin
         quot     = {3'd0, prod_ff[63:itoa_pkg::RECIP_SHIFT]};
         rem_full = mag_ff - (quot << 3) - (quot << 1);
      end
   end
   assign rem = rem_full[3:0];

   assign emit_any = cmd.emit_sign | cmd.emit_pad | cmd.emit_digit;
   assign rd_idx   = ndig_ff - IW'(1);

   always_comb begin
      mag_in   = mag_ff;
      width_in = width_ff;
      ndig_in  = ndig_ff;
      if (cmd.load) begin
         mag_in  = neg_new ? (32'd0 - in_value) : in_value;
         ndig_in = '0;
         if (neg_new) begin
            width_in = (sat_w != 6'd0) ? WW'(sat_w - 6'd1) : '0;
         end else begin
            width_in = WW'(sat_w);
         end
      end else if (cmd.div) begin
         mag_in  = quot;
         ndig_in = ndig_ff + IW'(1);
      end else if (cmd.emit_pad) begin
         width_in = width_ff - WW'(1);
      end else if (cmd.emit_digit) begin
         ndig_in = rd_idx;
      end
   end

   always_comb begin
      status.negative   = neg_ff;
      status.mag_done   = (quot == 32'd0) ||
                          (ndig_ff == IW'(itoa_pkg::DIGIT_SLOTS - 1));
      status.pad_left   = (width_ff > WW'(ndig_ff));
      status.last_digit = (ndig_ff == IW'(1));
      status.out_free   = !out_valid_ff || rsp_tready;
   end

   assign out_valid_in = emit_any ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      width_ff <= width_in;
      ndig_ff  <= ndig_in;
      if (cmd.load) begin
         hex_ff      <= (itoa_pkg::op_type'(in_op) inside
                         {itoa_pkg::OP_LHEX, itoa_pkg::OP_UHEX});
         upper_ff    <= (itoa_pkg::op_type'(in_op) == itoa_pkg::OP_UHEX);
         zero_pad_ff <= in_zero_pad;
         neg_ff      <= neg_new;
      end
      if (cmd.mul) begin
         prod_ff <= 64'(mag_ff) * 64'(itoa_pkg::RECIP_10);
      end
      if (cmd.div) begin
         slot_ff[ndig_ff] <= rem;
      end
      if (cmd.emit_sign) begin
         out_char_ff <= itoa_pkg::CHAR_MINUS;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_pad) begin
         out_char_ff <= zero_pad_ff ? itoa_pkg::CHAR_ZERO : itoa_pkg::CHAR_SPACE;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         out_char_ff <= itoa_pkg::digit_to_ascii(slot_ff[rd_idx], upper_ff);
         out_last_ff <= (ndig_ff == IW'(1));
      end
   end

   assign rsp_tvalid     = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_last       = out_last_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.div, cmd.emit_sign, cmd.emit_pad, cmd.emit_digit}))
      else $error("more than one datapath command");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_any |-> (!out_valid_ff || rsp_tready))
      else $error("output beat overwritten before taken");

   a_digit_present: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (ndig_ff != '0))
      else $error("digit emitted with empty slots");

   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> (ndig_ff < IW'(itoa_pkg::DIGIT_SLOTS)))
      else $error("digit slot overflow");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && ndig_ff == IW'(1)) |=> (ndig_ff == '0) && out_last_ff)
      else $error("last digit did not close the argument");

endmodule
